// ===== hw/rtl/a2i_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// a2i_pkg
// Shared types, character codes and sizes of the string-to-integer parser.
// ----------------------------------------------------------------------------
package a2i_pkg;

    localparam int MAX_STRING_LEN = 4096;
    localparam int VALUE_BITS     = 64;
    localparam int POS_W          = $clog2(MAX_STRING_LEN + 1);
    localparam int BASE_W         = 6;
    localparam int CHAR_W         = 8;

    localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE     = 6'd1;
    localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCTAL   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DECIMAL = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;

    localparam logic [CHAR_W-1:0] CHAR_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_BLANK      = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_BIAS = 8'd55;  // 'A' - 10
    localparam logic [CHAR_W-1:0] CHAR_LOWER_BIAS = 8'd87;  // 'a' - 10
    localparam logic [CHAR_W-1:0] CHAR_NON_DIGIT  = 8'h01;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_START,
        PH_ZERO,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        DS_NONE,
        DS_SEEN,
        DS_OVF
    } t_digit_status;

    typedef struct packed {
        logic              is_space;
        logic              is_minus;
        logic              is_plus;
        logic              is_zero;
        logic              is_x;
        logic              is_alnum;
        logic [BASE_W-1:0] digit;
    } t_char_class;

    typedef struct packed {
        logic [VALUE_BITS-1:0] magnitude;
        logic                  negative;
        logic                  found;
        logic                  overflow;
        logic [POS_W-1:0]      offset;
    } t_result;

endpackage
`default_nettype wire

// ===== hw/rtl/a2i_char_class.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// a2i_char_class
// Classifies one character and gives its digit value for radix up to 36.
// ----------------------------------------------------------------------------
module a2i_char_class
    import a2i_pkg::*;
(
    input  wire logic [CHAR_W-1:0] i_char,
    output t_char_class            o_class
);

    logic [CHAR_W-1:0] w_value;
    logic              w_num;
    logic              w_upper;
    logic              w_lower;

    always_comb begin
        w_num   = (i_char >= CHAR_DIGIT_0) && (i_char <= CHAR_DIGIT_9);
        w_upper = (i_char >= CHAR_UPPER_A) && (i_char <= CHAR_UPPER_Z);
        w_lower = (i_char >= CHAR_LOWER_A) && (i_char <= CHAR_LOWER_Z);
        if (w_num) begin
            w_value = i_char - CHAR_DIGIT_0;
        end else if (w_upper) begin
            w_value = i_char - CHAR_UPPER_BIAS;
        end else begin
            w_value = i_char - CHAR_LOWER_BIAS;
        end
        o_class.is_space = (i_char == CHAR_BLANK) ||
                           ((i_char >= CHAR_TAB) && (i_char <= CHAR_CR));
        o_class.is_minus = (i_char == CHAR_MINUS);
        o_class.is_plus  = (i_char == CHAR_PLUS);
        o_class.is_zero  = (i_char == CHAR_DIGIT_0);
        o_class.is_x     = (i_char == CHAR_UPPER_X) || (i_char == CHAR_LOWER_X);
        o_class.is_alnum = w_num || w_upper || w_lower;
        o_class.digit    = w_value[BASE_W-1:0];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/a2i_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// a2i_accum
// Multiply-add of one digit into the magnitude, saturating at the signed
// limit. The overflow test acc * base + digit > limit is the exact form of
// acc > (limit - digit) / base for nonnegative integers.
// ----------------------------------------------------------------------------
module a2i_accum
    import a2i_pkg::*;
(
    input  wire logic [VALUE_BITS-1:0] i_acc,
    input  wire logic [BASE_W-1:0]     i_base,
    input  wire logic [BASE_W-1:0]     i_digit,
    input  wire logic                  i_negative,
    output logic      [VALUE_BITS-1:0] o_acc,
    output logic                       o_overflow
);

    localparam int SUM_W = VALUE_BITS + BASE_W + 1;

    logic [VALUE_BITS-1:0] w_limit;
    logic [SUM_W-1:0]      w_sum;

    always_comb begin
        // Magnitude limit: 2^(N-1) for a negative result, 2^(N-1) - 1 otherwise.
        w_limit = {1'b1, {(VALUE_BITS-1){1'b0}}} - VALUE_BITS'(!i_negative);
        w_sum   = SUM_W'(i_acc) * SUM_W'(i_base) + SUM_W'(i_digit);
        o_overflow = w_sum > SUM_W'(w_limit);
        o_acc      = o_overflow ? w_limit : w_sum[VALUE_BITS-1:0];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/a2i_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// a2i_parser
// Per-string parse state: phase, sign, magnitude, base and positions.
// Consumes one byte per step and presents the result of a string that ends.
// ----------------------------------------------------------------------------
module a2i_parser
    import a2i_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_emit,
    input  wire logic [CHAR_W-1:0] i_byte,
    input  wire logic [BASE_W-1:0] i_number_base,
    output t_result                o_result
);

    t_phase                r_phase;
    t_phase                n_phase;
    logic                  r_neg;
    logic                  n_neg;
    logic [VALUE_BITS-1:0] r_acc;
    logic [VALUE_BITS-1:0] n_acc;
    t_digit_status         r_status;
    t_digit_status         n_status;
    logic [BASE_W-1:0]     r_base;
    logic [BASE_W-1:0]     n_base;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      n_pos;
    logic [POS_W-1:0]      r_stop;
    logic [POS_W-1:0]      n_stop;

    logic                  w_parse;
    logic                  w_pos_full;
    logic [CHAR_W-1:0]     w_char;
    t_char_class           w_cls;
    logic [BASE_W-1:0]     w_cfg_base;
    logic [BASE_W-1:0]     w_start_base;
    logic [BASE_W-1:0]     w_zero_base;
    logic [BASE_W-1:0]     w_take_base;
    logic [BASE_W-1:0]     w_eff_base;
    logic                  w_in_start;
    logic                  w_prefix_zero;
    logic                  w_start_take;
    logic                  w_zero_x;
    logic                  w_zero_take;
    logic                  w_take;
    logic                  w_digit_ok;
    t_digit_status         w_status_in;
    logic [VALUE_BITS-1:0] w_sum_acc;
    logic                  w_sum_ovf;
    t_phase                w_p_phase;
    logic                  w_p_neg;
    logic [VALUE_BITS-1:0] w_p_acc;
    t_digit_status         w_p_status;
    logic [BASE_W-1:0]     w_p_base;
    logic [POS_W-1:0]      w_p_stop;
    logic [POS_W-1:0]      w_pos_inc;

    // Bytes past the length limit are parsed as a non-digit.
    assign w_parse    = i_step && (i_byte != CHAR_NUL);
    assign w_pos_full = r_pos >= POS_W'(MAX_STRING_LEN);
    assign w_char     = w_pos_full ? CHAR_NON_DIGIT : i_byte;
    assign w_pos_inc  = r_pos + POS_W'(1);

    a2i_char_class u_class (
        .i_char  (w_char),
        .o_class (w_cls)
    );

    a2i_accum u_accum (
        .i_acc      (r_acc),
        .i_base     (w_eff_base),
        .i_digit    (w_cls.digit),
        .i_negative (r_neg),
        .o_acc      (w_sum_acc),
        .o_overflow (w_sum_ovf)
    );

    // Decode of what this byte does in the current phase.
    always_comb begin
        w_cfg_base   = (i_number_base == BASE_ONE) ? BASE_AUTO : i_number_base;
        w_start_base = (w_cfg_base == BASE_AUTO) ? BASE_DECIMAL : w_cfg_base;
        w_zero_base  = (r_base == BASE_AUTO) ? BASE_OCTAL : r_base;
        w_in_start   = w_parse &&
                       (((r_phase == PH_SPACE) && !w_cls.is_space && !w_cls.is_minus &&
                         !w_cls.is_plus) || (r_phase == PH_START));
        w_prefix_zero = w_in_start && w_cls.is_zero &&
                        ((w_cfg_base == BASE_AUTO) || (w_cfg_base == BASE_HEX));
        w_start_take = w_in_start && !w_prefix_zero;
        w_zero_x     = w_parse && (r_phase == PH_ZERO) && w_cls.is_x;
        w_zero_take  = w_parse && (r_phase == PH_ZERO) && !w_cls.is_x;
        w_take       = w_start_take || w_zero_take || (w_parse && (r_phase == PH_DIGITS));
        if (w_start_take) begin
            w_take_base = w_start_base;
        end else if (w_zero_take) begin
            w_take_base = w_zero_base;
        end else begin
            w_take_base = r_base;
        end
        w_eff_base  = (w_take_base < BASE_MIN) ? BASE_DECIMAL : w_take_base;
        w_digit_ok  = w_cls.is_alnum && (w_cls.digit < w_eff_base);
        w_status_in = (w_zero_take && (r_status == DS_NONE)) ? DS_SEEN : r_status;
    end

    // Next phase.
    always_comb begin
        w_p_phase = r_phase;
        if (w_parse) begin
            case (r_phase)
                PH_SPACE: begin
                    if (w_cls.is_space) begin
                        w_p_phase = PH_SPACE;
                    end else if (w_cls.is_minus || w_cls.is_plus) begin
                        w_p_phase = PH_START;
                    end else if (w_prefix_zero) begin
                        w_p_phase = PH_ZERO;
                    end else begin
                        w_p_phase = w_digit_ok ? PH_DIGITS : PH_STOP;
                    end
                end
                PH_START: begin
                    if (w_prefix_zero) begin
                        w_p_phase = PH_ZERO;
                    end else begin
                        w_p_phase = w_digit_ok ? PH_DIGITS : PH_STOP;
                    end
                end
                PH_ZERO: begin
                    if (w_cls.is_x) begin
                        w_p_phase = PH_DIGITS;
                    end else begin
                        w_p_phase = w_digit_ok ? PH_DIGITS : PH_STOP;
                    end
                end
                PH_DIGITS: w_p_phase = w_digit_ok ? PH_DIGITS : PH_STOP;
                PH_STOP:   w_p_phase = PH_STOP;
                default:   w_p_phase = PH_STOP;
            endcase
        end
        n_phase = i_emit ? PH_SPACE : (i_step ? w_p_phase : r_phase);
    end

    // Datapath updates and the result of an ending string.
    always_comb begin
        w_p_neg    = r_neg || (w_parse && (r_phase == PH_SPACE) && w_cls.is_minus);
        w_p_base   = r_base;
        w_p_stop   = r_stop;
        w_p_acc    = r_acc;
        w_p_status = w_take ? w_status_in : r_status;
        if (w_prefix_zero) begin
            w_p_base = w_cfg_base;
            w_p_stop = w_pos_inc;
        end
        if (w_start_take) begin
            w_p_base = w_start_base;
        end
        if (w_zero_x) begin
            w_p_base = BASE_HEX;
            w_p_stop = '0;
        end
        if (w_zero_take) begin
            w_p_base = w_zero_base;
        end
        if (w_take && w_digit_ok) begin
            w_p_stop = w_pos_inc;
            if (w_status_in != DS_OVF) begin
                w_p_acc    = w_sum_acc;
                w_p_status = w_sum_ovf ? DS_OVF : DS_SEEN;
            end
        end

        // A held leading zero at the end of the string counts as a digit.
        o_result.found     = (w_p_status != DS_NONE) || (w_p_phase == PH_ZERO);
        o_result.overflow  = (w_p_status == DS_OVF);
        o_result.negative  = w_p_neg;
        o_result.magnitude = o_result.found ? w_p_acc : '0;
        o_result.offset    = o_result.found ? w_p_stop : '0;

        if (i_emit) begin
            n_neg    = 1'b0;
            n_acc    = '0;
            n_status = DS_NONE;
            n_base   = BASE_AUTO;
            n_stop   = '0;
            n_pos    = '0;
        end else begin
            n_neg    = w_p_neg;
            n_acc    = w_p_acc;
            n_status = w_p_status;
            n_base   = w_p_base;
            n_stop   = w_p_stop;
            n_pos    = (w_parse && !w_pos_full) ? w_pos_inc : r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SPACE;
            r_neg    <= 1'b0;
            r_acc    <= '0;
            r_status <= DS_NONE;
            r_base   <= BASE_AUTO;
            r_pos    <= '0;
            r_stop   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_acc    <= n_acc;
            r_status <= n_status;
            r_base   <= n_base;
            r_pos    <= n_pos;
            r_stop   <= n_stop;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ascii_to_integer_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_to_integer_parser
// Streaming string-to-integer parser with strtol behavior and a 64-bit result.
//
// Usage: characters arrive one per transfer on the input channel
// (i_in_valid / o_in_stall, payload i_char_byte and i_end_of_string). A zero
// byte, or a byte with i_end_of_string set, closes the string; a marked
// nonzero byte is parsed before the string closes. Each closed string yields
// exactly one transfer on the output channel (o_out_valid / i_out_stall)
// carrying the value, the digits-found and overflow flags and the end offset.
// Other bytes yield no output. The radix is written through i_cfg_we /
// i_cfg_data; the user must write it only while the block is idle, which the
// block does not enforce. It is sampled at the first byte after whitespace
// and sign. A byte is captured in the input register at its transfer and is
// parsed from there; the parse of a closing byte loads its result into the
// output register, which offers it. Throughput is one byte per cycle while
// no closing byte waits on a stalled receiver; the loop through the magnitude
// register (one 64 x 6 multiply-add and compare) sets the cycle time.
// When the receiver stalls, the result is held in the output register and a
// further byte that does not close a string is still parsed; a closing byte
// waits in the input register and the input stalls behind it.
// Reset clears the parse state and both channels and sets the radix to 10.
// ----------------------------------------------------------------------------
module ascii_to_integer_parser
    import a2i_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration register.
    input  wire logic                         i_cfg_we,
    input  wire logic [BASE_W-1:0]            i_cfg_data,
    // Input channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [CHAR_W-1:0]            i_char_byte,
    input  wire logic                         i_end_of_string,
    // Output channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [VALUE_BITS-1:0]      o_parsed_value,
    output logic                              o_digits_found,
    output logic                              o_overflowed,
    output logic [POS_W-1:0]                  o_end_offset
);

    logic [BASE_W-1:0] r_number_base;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_byte;
    logic              r_in_end;

    logic              r_out_valid;
    t_result           r_out;

    logic              w_emit;
    logic              w_out_free;
    logic              w_step;
    logic              w_in_take;
    t_result           w_result;

    // The held byte closes a string when it is zero or carries the end mark.
    assign w_emit     = (r_in_byte == CHAR_NUL) || r_in_end;
    // The output register can take a result when empty or drained this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    // A held byte is consumed unless its result would find the output full.
    assign w_step     = r_in_valid && (!w_emit || w_out_free);
    assign o_in_stall = r_in_valid && !w_step;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_DECIMAL;
        end else if (i_cfg_we) begin
            r_number_base <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_char_byte;
            r_in_end  <= i_end_of_string;
        end
    end

    a2i_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_emit        (w_step && w_emit),
        .i_byte        (r_in_byte),
        .i_number_base (r_number_base),
        .o_result      (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out <= w_result;
        end
    end

    // The magnitude is kept unsigned; the sign is applied on the way out.
    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = r_out.negative ? -r_out.magnitude : r_out.magnitude;
    assign o_digits_found = r_out.found;
    assign o_overflowed   = r_out.overflow;
    assign o_end_offset   = r_out.offset;

endmodule
`default_nettype wire

// ===== hw/rtl/a2i_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// a2i_checker
// Port-level checks on the result channel of the parser.
// ----------------------------------------------------------------------------
module a2i_checker
    import a2i_pkg::*;
(
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic signed [VALUE_BITS-1:0] o_parsed_value,
    input wire logic                         o_digits_found,
    input wire logic                         o_overflowed,
    input wire logic [POS_W-1:0]             o_end_offset
);

    localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_parsed_value) &&
            $stable(o_digits_found) && $stable(o_overflowed) && $stable(o_end_offset)))
        else $error("stalled result changed");

    // A saturated result has digits and sits at one of the two limits.
    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflowed) |-> (o_digits_found &&
            ((o_parsed_value == VALUE_MIN) || (o_parsed_value == VALUE_MAX))))
        else $error("overflow without saturated value");

    // Without digits the value and end offset are zero and no overflow is flagged.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_digits_found) |-> ((o_parsed_value == '0) &&
            (o_end_offset == '0) && !o_overflowed))
        else $error("empty parse returned data");

    // The end offset never passes the string length limit.
    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_end_offset <= POS_W'(MAX_STRING_LEN)))
        else $error("end offset beyond length limit");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind ascii_to_integer_parser a2i_checker u_a2i_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_parsed_value (o_parsed_value),
    .o_digits_found (o_digits_found),
    .o_overflowed   (o_overflowed),
    .o_end_offset   (o_end_offset)
);
`default_nettype wire
